// ----- rtl/srg_pkg.sv -----
package srg_pkg;

   localparam int CHUNK_MAX_DEFAULT = 64;
   localparam int CHUNK_LEN_W       = 7;
   localparam logic [CHUNK_LEN_W-1:0] CHUNK_LEN_RESET = 7'd64;

   typedef struct packed {
      logic [63:0] value;
      logic        end_of_data;
   } req_type;

   typedef struct packed {
      logic [63:0] sorted_value;
      logic        run_select;
      logic        chunk_last;
   } rsp_type;

   // contents of one sorting cell; an empty cell ranks above every word
   typedef struct packed {
      logic        valid;
      logic [63:0] value;
   } cell_state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic        insert;
      logic        shift;
      logic [63:0] word;
   } cell_ctrl_type;

endpackage

// ----- rtl/srg_cell.sv -----
module srg_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  srg_pkg::cell_ctrl_type ctrl,
   input  srg_pkg::cell_state_type left_st,
   input  logic                   left_lt,
   input  srg_pkg::cell_state_type right_st,
   output srg_pkg::cell_state_type st,
   output logic                   lt
);
   import srg_pkg::*;

   cell_state_type st_ff, st_in;

   // new word sorts ahead of this cell's contents
   assign lt = !st_ff.valid || (ctrl.word < st_ff.value);
   assign st = st_ff;

   always_comb begin
      st_in = st_ff;
      if (ctrl.shift) begin
         st_in = right_st;
      end else if (ctrl.insert) begin
         if (left_lt) begin
            st_in = left_st;
         end else if (lt) begin
            st_in.valid = 1'b1;
            st_in.value = ctrl.word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else begin
         st_ff.valid <= st_in.valid;
      end
      st_ff.value <= st_in.value;
   end

endmodule

// ----- rtl/sorted_run_generator_top.sv -----
// Words are taken one per cycle into an insertion chain while a chunk fills.
// The word that closes a chunk shows its smallest result the next cycle; the
// n words of the chunk then leave one per cycle while rsp_stall is low.
// Input is stalled while the chain drains.
// Synchronous reset empties the chain, clears the counters, selects run 0 and
// sets chunk_len to 64.
module sorted_run_generator_top #(
   parameter int CHUNK_MAX = srg_pkg::CHUNK_MAX_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  srg_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output srg_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [srg_pkg::CHUNK_LEN_W-1:0]    csr_data
);
   import srg_pkg::*;

   localparam int CW = $clog2(CHUNK_MAX + 1);
   localparam int LW = (CW > CHUNK_LEN_W) ? CW : CHUNK_LEN_W;

   typedef enum logic {FILL, DRAIN} state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           remain_ff, remain_in;
   logic                    next_run_ff, next_run_in;
   logic                    drain_run_ff, drain_run_in;
   logic [CHUNK_LEN_W-1:0]  chunk_len_ff, chunk_len_in;

   cell_ctrl_type           ctrl;
   cell_state_type          cell_st [CHUNK_MAX+1];
   logic                    cell_lt [CHUNK_MAX];
   cell_state_type          empty_st;

   logic                    take_req, take_rsp, close;
   logic [CW-1:0]           new_count;
   logic [LW-1:0]           len_ext, eff_len;

   assign take_req  = req_valid && !req_stall;
   assign take_rsp  = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != FILL);
   assign rsp_valid = (state_ff == DRAIN);
   assign csr_ready = 1'b1;

   assign ctrl.insert = take_req;
   assign ctrl.shift  = take_rsp;
   assign ctrl.word   = req_data.value;

   assign empty_st.valid = 1'b0;
   assign empty_st.value = '0;

   // entry CHUNK_MAX is the empty right end of the chain
   assign cell_st[CHUNK_MAX] = empty_st;

   genvar i;
   generate
      for (i = 0; i < CHUNK_MAX; i++) begin : g_cell
         srg_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .left_st  ((i == 0) ? empty_st : cell_st[(i == 0) ? 0 : i-1]),
            .left_lt  ((i == 0) ? 1'b0 : cell_lt[(i == 0) ? 0 : i-1]),
            .right_st (cell_st[i+1]),
            .st       (cell_st[i]),
            .lt       (cell_lt[i])
         );
      end
   endgenerate

   assign rsp_data.sorted_value = cell_st[0].value;
   assign rsp_data.run_select   = drain_run_ff;
   assign rsp_data.chunk_last   = (remain_ff == CW'(1));

   // chunk length 0 acts as 1, lengths above the chain saturate
   always_comb begin
      len_ext = LW'(chunk_len_ff);
      if (len_ext == '0) begin
         eff_len = LW'(1);
      end else if (len_ext > LW'(CHUNK_MAX)) begin
         eff_len = LW'(CHUNK_MAX);
      end else begin
         eff_len = len_ext;
      end
   end

   assign new_count = count_ff + CW'(1);
   assign close     = (LW'(new_count) >= eff_len) || req_data.end_of_data;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      next_run_in  = next_run_ff;
      drain_run_in = drain_run_ff;
      chunk_len_in = chunk_len_ff;
      if (csr_valid && csr_ready) begin
         chunk_len_in = csr_data;
      end
      case (state_ff)
         FILL: begin
            if (take_req) begin
               if (close) begin
                  count_in     = '0;
                  remain_in    = new_count;
                  drain_run_in = next_run_ff;
                  next_run_in  = req_data.end_of_data ? 1'b0 : !next_run_ff;
                  state_in     = DRAIN;
               end else begin
                  count_in = new_count;
               end
            end
         end
         DRAIN: begin
            if (take_rsp) begin
               remain_in = remain_ff - CW'(1);
               if (remain_ff == CW'(1)) begin
                  state_in = FILL;
               end
            end
         end
         default: begin
            state_in = FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FILL;
         count_ff     <= '0;
         remain_ff    <= '0;
         next_run_ff  <= 1'b0;
         drain_run_ff <= 1'b0;
         chunk_len_ff <= CHUNK_LEN_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         next_run_ff  <= next_run_in;
         drain_run_ff <= drain_run_in;
         chunk_len_ff <= chunk_len_in;
      end
   end

endmodule

// ----- sim/tb_sorted_run_generator_top.sv -----
module tb_sorted_run_generator_top;
   import srg_pkg::*;

   localparam int CHUNK_MAX     = 64;
   localparam int RANDOM_WORDS  = 110;
   localparam int QUIET_AFTER   = 85;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD     = 160;
   localparam int DRAIN_LIMIT   = 1500;
   localparam int IDLE_LIMIT    = 2000;

   // Keeps the open chunk in ascending order and queues the words of every
   // chunk that a transaction closes.
   class run_scoreboard;
      logic [63:0]            held [CHUNK_MAX];
      int unsigned            held_count;
      logic [CHUNK_LEN_W-1:0] chunk_len;
      logic                   next_run;
      rsp_type                sorted_words [$];

      function new();
         held_count = 0;
         chunk_len  = CHUNK_LEN_RESET;
         next_run   = 1'b0;
      endfunction

      function void write_len(logic [CHUNK_LEN_W-1:0] len);
         chunk_len = len;
      endfunction

      function int unsigned close_at();
         int unsigned n;
         n = chunk_len;
         if (n == 0) n = 1;
         if (n > CHUNK_MAX) n = CHUNK_MAX;
         return n;
      endfunction

      function int unsigned pending();
         return sorted_words.size();
      endfunction

      function void note_word(req_type item);
         int unsigned pos;
         rsp_type     word;
         if (held_count < CHUNK_MAX) begin
            pos = held_count;
            while (pos > 0 && held[pos-1] > item.value) begin
               held[pos] = held[pos-1];
               pos--;
            end
            held[pos] = item.value;
            held_count++;
         end
         if (held_count < close_at() && !item.end_of_data) return;
         for (int unsigned k = 0; k < held_count; k++) begin
            word.sorted_value = held[k];
            word.run_select   = next_run;
            word.chunk_last   = (k + 1 == held_count);
            sorted_words.push_back(word);
         end
         held_count = 0;
         next_run   = item.end_of_data ? 1'b0 : ~next_run;
      endfunction

      // empty string when the transaction matches
      function string check(rsp_type got);
         rsp_type want;
         string   msg;
         msg = "";
         if (sorted_words.size() == 0)
            return $sformatf("unexpected word %h", got.sorted_value);
         want = sorted_words.pop_front();
         if (got.sorted_value !== want.sorted_value)
            msg = {msg, $sformatf(" sorted_value %h/%h", got.sorted_value, want.sorted_value)};
         if (got.run_select !== want.run_select)
            msg = {msg, $sformatf(" run_select %b/%b", got.run_select, want.run_select)};
         if (got.chunk_last !== want.chunk_last)
            msg = {msg, $sformatf(" chunk_last %b/%b", got.chunk_last, want.chunk_last)};
         return (msg == "") ? "" : {"mismatch got/want:", msg};
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CHUNK_LEN_W-1:0] csr_data  = '0;

   run_scoreboard board = new();
   int  errors     = 0;
   int  idle_count = 0;
   int  hold_left  = 0;
   int  burst_left = 0;
   bit  quiet      = 1'b0;

   always #2 clock = ~clock;

   sorted_run_generator_top #(
      .CHUNK_MAX(CHUNK_MAX)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   task automatic report(string msg);
      errors++;
      $display("ERROR @%0t %s", $time, msg);
   endtask

   task automatic send_word(logic [63:0] value, logic eod);
      req_type item;
      item.value       = value;
      item.end_of_data = eod;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.note_word(item);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_len(logic [CHUNK_LEN_W-1:0] len);
      csr_valid <= 1'b1;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.write_len(len);
   endtask

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return 64'd0;
         1:       return '1;
         2:       return 64'($urandom_range(0, 7));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // receiver: random stall bursts, plus one long hold-off requested by the stimulus
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (burst_left > 0) begin
         rsp_stall <= 1'b1;
         burst_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         burst_left = $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      string msg;
      if (!reset && rsp_valid && !rsp_stall) begin
         msg = board.check(rsp_data);
         if (msg != "") report(msg);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_count = 0;
      else
         idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned            sent;
      int unsigned            batch;
      int unsigned            phase;
      logic [CHUNK_LEN_W-1:0] len;
      logic                   eod;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // oversized length saturates; extremes and equal words in one short chunk
      write_len(7'd127);
      send_word(64'd0, 1'b0);
      send_word('1, 1'b0);
      send_word(64'd5, 1'b0);
      send_word(64'd5, 1'b0);
      send_word(64'd3, 1'b1);
      wait_idle();

      // zero length: every word is a chunk of its own, tags alternate
      write_len(7'd0);
      send_word(64'h8000_0000_0000_0000, 1'b0);
      send_word(64'h7fff_ffff_ffff_ffff, 1'b0);
      send_word(64'd1, 1'b0);
      send_word(64'd2, 1'b1);
      wait_idle();

      write_len(7'd1);
      send_word(64'd9, 1'b0);
      send_word(64'd8, 1'b0);
      wait_idle();

      // length lowered below the held count: next word flushes all three
      write_len(7'd3);
      send_word(64'd30, 1'b0);
      send_word(64'd10, 1'b0);
      wait_idle();
      write_len(7'd1);
      send_word(64'd20, 1'b0);
      wait_idle();

      write_len(7'd2);
      send_word(64'd44, 1'b1);
      send_word('1, 1'b0);
      send_word(64'd0, 1'b0);
      send_word(64'd7, 1'b0);
      send_word(64'd7, 1'b0);
      wait_idle();

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_WORDS) begin
         wait_idle();
         quiet = (sent >= QUIET_AFTER);
         case ($urandom_range(0, 9))
            0:       len = 7'd0;
            1:       len = 7'd127;
            2:       len = 7'd64;
            3:       len = 7'($urandom_range(0, 127));
            default: len = 7'($urandom_range(1, 6));
         endcase
         batch = $urandom_range(4, 16);
         if (phase == 2) begin
            // long receiver hold-off so the chain fills and input backs up
            len       = 7'd3;
            batch     = 18;
            hold_left = LONG_HOLD;
         end
         write_len(len);
         for (int unsigned i = 0; i < batch; i++) begin
            eod = ($urandom_range(0, 11) == 0) || (i == batch - 1 && $urandom_range(0, 2) == 0);
            send_word(pick_word(), eod);
         end
         sent += batch;
         phase++;
      end
      send_word(pick_word(), 1'b1);
      req_valid <= 1'b0;

      for (int i = 0; i < DRAIN_LIMIT && board.pending() != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0)
         report($sformatf("%0d words never emitted", board.pending()));

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
